@@ hw/rtl/pts_pkg.sv @@
// Shared types and codes for the piece table span engine.
// No dependencies; used by the top level and its checker.
package pts_pkg;

    // Operation codes
    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_INSERT = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_LOCATE = 3'd3;
    localparam logic [2:0] FN_FRAG   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_PROC = 5'b00100,
        S_WR   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/pts_span_mem.sv @@
// Span table storage: one write port, one read port, registered read data.
// No dependencies.
module pts_span_mem #(
    parameter int DW = 81,
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/piece_table_span_engine.sv @@
// Top level of the piece table span engine: sequencer over a banked span memory.
// Depends on pts_pkg and pts_span_mem.
//
// Usage
// - Command channel: an operation transfers when start is high and busy is low.
//   busy stays high while the sequencer walks the span table.
// - Config channel: i_cfg_data (original_length) transfers on i_cfg_valid;
//   o_cfg_ready is always high. Write it only while the block is idle.
// - Results: each result is on the o_* ports for one cycle with o_strobe high;
//   the receiver cannot stall, so nothing is held back. o_last marks the final
//   result of an operation. fragments gives one result per covered span.
// - Sequencing: load, no-op and requests refused on arrival answer in the
//   next cycle. Others walk the table, a read state then a process state per
//   span; locate and fragments answer as they walk, edits add a write state per
//   span piece written and a finish state and answer as busy falls.
// - The table lives in two banks of one memory; edits stream the live bank into
//   the spare bank and swap on success, so a flagged edit leaves it untouched
//   and reads never meet writes to the same entry.
// - Reset clears the span count, document length, append fill and
//   original_length; memory contents need no clearing.
module piece_table_span_engine #(
    parameter int MAX_SPANS = 32,
    parameter int POS_BITS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [39:0] i_position,
    input  logic [39:0] i_span_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [39:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [5:0]  o_piece_index,
    output logic [39:0] o_piece_offset,
    output logic        o_frag_source,
    output logic [39:0] o_frag_start,
    output logic [39:0] o_frag_length,
    output logic [39:0] o_doc_length,
    output logic [39:0] o_append_start,
    output logic        o_last
);

    localparam int PW  = POS_BITS;
    localparam int DW  = 1 + 2 * PW;
    localparam int IW  = $clog2(MAX_SPANS);
    localparam int CW  = $clog2(MAX_SPANS + 1);
    localparam int WCW = $clog2(MAX_SPANS + 3);
    localparam logic [PW-1:0] PMASK = {PW{1'b1}};

    // Port width adaptation
    logic [PW-1:0] pos_in, len_in, cfg_in;

    // Table state
    pts_pkg::t_state r_state, n_state;
    logic            r_bank, n_bank;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_doc, n_doc;
    logic [PW-1:0]   r_app, n_app;
    logic [PW-1:0]   r_orig;

    // Operation context
    logic [2:0]      r_func, n_func;
    logic [PW-1:0]   r_pos, n_pos, r_len, n_len, r_end, n_end;
    logic [IW-1:0]   r_i, n_i;
    logic [PW-1:0]   r_run, n_run;
    logic [WCW-1:0]  r_wc, n_wc;
    logic [1:0]      r_need, n_need;
    logic [DW-1:0]   r_pc [3];
    logic [DW-1:0]   n_pc [3];
    logic [1:0]      r_np, n_np, r_pi, n_pi;

    // Result registers
    logic            r_strobe, n_strobe;
    logic [1:0]      r_status, n_status;
    logic [CW-1:0]   r_pidx, n_pidx;
    logic [PW-1:0]   r_poff, n_poff, r_fst, n_fst, r_fln, n_fln;
    logic [PW-1:0]   r_odoc, n_odoc, r_oapp, n_oapp;
    logic            r_fsrc, n_fsrc, r_last, n_last;

    // Memory port
    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    logic [DW-1:0]   wr_data;
    logic [DW-1:0]   rd_data;

    // Span fields from the read port
    logic            rs;
    logic [PW-1:0]   rst, rl, eo, newcut, rmv_st, rmv_ln, lft_ln;
    logic            is_edit, at_last, ins_end, do_adv;
    logic            p_in, e_in, full;
    logic [WCW-1:0]  wcf;
    logic [CW:0]     need_sum;
    logic [PW-1:0]   span_avail;

    genvar g;
    generate
        for (g = 0; g < PW; g++) begin : g_in
            if (g < 40) begin : g_take
                assign pos_in[g] = i_position[g];
                assign len_in[g] = i_span_length[g];
                assign cfg_in[g] = i_cfg_data[g];
            end else begin : g_zero
                assign pos_in[g] = 1'b0;
                assign len_in[g] = 1'b0;
                assign cfg_in[g] = 1'b0;
            end
        end
        for (g = 0; g < 40; g++) begin : g_out
            if (g < PW) begin : g_take
                assign o_piece_offset[g] = r_poff[g];
                assign o_frag_start[g]   = r_fst[g];
                assign o_frag_length[g]  = r_fln[g];
                assign o_doc_length[g]   = r_odoc[g];
                assign o_append_start[g] = r_oapp[g];
            end else begin : g_zero
                assign o_piece_offset[g] = 1'b0;
                assign o_frag_start[g]   = 1'b0;
                assign o_frag_length[g]  = 1'b0;
                assign o_doc_length[g]   = 1'b0;
                assign o_append_start[g] = 1'b0;
            end
        end
        for (g = 0; g < 6; g++) begin : g_idx
            if (g < CW) begin : g_take
                assign o_piece_index[g] = r_pidx[g];
            end else begin : g_zero
                assign o_piece_index[g] = 1'b0;
            end
        end
    endgenerate

    pts_span_mem #(
        .DW(DW),
        .AW(IW + 1)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr({~r_bank, wr_idx}),
        .i_wdata(wr_data),
        .i_raddr({r_bank, r_i}),
        .o_rdata(rd_data)
    );

    assign rs  = rd_data[DW-1];
    assign rst = rd_data[2*PW-1:PW];
    assign rl  = rd_data[PW-1:0];
    assign eo  = r_run + rl;

    // Cut points strictly inside the current span
    assign p_in   = (r_pos > r_run) && (r_pos < eo);
    assign e_in   = (r_end > r_run) && (r_end < eo);
    assign newcut = r_pos - r_run;
    assign lft_ln = ((eo < r_pos) ? eo : r_pos) - r_run;
    assign rmv_st = rst + ((r_end > r_run) ? (r_end - r_run) : '0);
    assign rmv_ln = eo - ((r_end > r_run) ? r_end : r_run);
    assign span_avail = ((eo < r_end) ? eo : r_end) - ((r_pos > r_run) ? r_pos : r_run);

    assign is_edit  = (r_func == pts_pkg::FN_INSERT) || (r_func == pts_pkg::FN_REMOVE);
    assign at_last  = ((CW'(r_i) + CW'(1)) == r_count);
    assign ins_end  = (r_func == pts_pkg::FN_INSERT) && (r_pos == r_doc);
    assign wcf      = r_wc + (ins_end ? WCW'(1) : WCW'(0));
    assign need_sum = (CW + 1)'(r_count) + (CW + 1)'(r_need);
    assign full     = (r_func == pts_pkg::FN_INSERT) ? (wcf > WCW'(MAX_SPANS))
                                                     : (need_sum > (CW + 1)'(MAX_SPANS));

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_count  = r_count;
        n_doc    = r_doc;
        n_app    = r_app;
        n_func   = r_func;
        n_pos    = r_pos;
        n_len    = r_len;
        n_end    = r_end;
        n_i      = r_i;
        n_run    = r_run;
        n_wc     = r_wc;
        n_need   = r_need;
        n_pc     = r_pc;
        n_np     = r_np;
        n_pi     = r_pi;
        n_strobe = 1'b0;
        n_status = pts_pkg::ST_OK;
        n_pidx   = '0;
        n_poff   = '0;
        n_fsrc   = 1'b0;
        n_fst    = '0;
        n_fln    = '0;
        n_odoc   = r_doc;
        n_oapp   = '0;
        n_last   = 1'b1;
        wr_en    = 1'b0;
        wr_idx   = r_wc[IW-1:0];
        wr_data  = r_pc[r_pi];
        do_adv   = 1'b0;

        case (r_state)
            pts_pkg::S_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_pos  = pos_in;
                    n_len  = len_in;
                    n_end  = pos_in + len_in;
                    n_i    = '0;
                    n_run  = '0;
                    n_wc   = '0;
                    n_need = '0;
                    n_strobe = 1'b1;
                    case (i_func)
                        pts_pkg::FN_LOAD: begin
                            n_count = (r_orig != '0) ? CW'(1) : CW'(0);
                            n_doc   = r_orig;
                            n_odoc  = r_orig;
                            n_app   = '0;
                            n_bank  = ~r_bank;
                            wr_en   = (r_orig != '0);
                            wr_idx  = '0;
                            wr_data = {1'b0, {PW{1'b0}}, r_orig};
                        end
                        pts_pkg::FN_INSERT: begin
                            if (len_in == '0) begin
                                n_status = pts_pkg::ST_OK;
                            end else if (pos_in > r_doc || len_in > (PMASK - r_doc) ||
                                         len_in > (PMASK - r_app)) begin
                                n_status = pts_pkg::ST_RANGE;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = (r_count == '0) ? pts_pkg::S_FIN : pts_pkg::S_RD;
                            end
                        end
                        pts_pkg::FN_REMOVE: begin
                            if (len_in == '0) begin
                                n_status = pts_pkg::ST_OK;
                            end else if (len_in > r_doc || pos_in > (r_doc - len_in)) begin
                                n_status = pts_pkg::ST_RANGE;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = pts_pkg::S_RD;
                            end
                        end
                        pts_pkg::FN_LOCATE: begin
                            if (pos_in > r_doc) begin
                                n_status = pts_pkg::ST_RANGE;
                            end else if (pos_in == r_doc) begin
                                n_pidx = r_count;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = pts_pkg::S_RD;
                            end
                        end
                        pts_pkg::FN_FRAG: begin
                            if (len_in == '0 || pos_in >= r_doc) begin
                                n_status = pts_pkg::ST_EMPTY;
                            end else begin
                                n_strobe = 1'b0;
                                n_end = pos_in + ((len_in < (r_doc - pos_in)) ?
                                                  len_in : (r_doc - pos_in));
                                n_state = pts_pkg::S_RD;
                            end
                        end
                        default: begin
                            n_status = pts_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            pts_pkg::S_RD: begin
                n_state = pts_pkg::S_PROC;
            end

            pts_pkg::S_PROC: begin
                n_run = eo;
                case (r_func)
                    pts_pkg::FN_INSERT: begin
                        n_pi = '0;
                        n_state = pts_pkg::S_WR;
                        if (r_pos == r_run) begin
                            n_pc[0] = {1'b1, r_app, r_len};
                            n_pc[1] = {rs, rst, rl};
                            n_np    = 2'd2;
                        end else if (p_in) begin
                            n_pc[0] = {rs, rst, newcut};
                            n_pc[1] = {1'b1, r_app, r_len};
                            n_pc[2] = {rs, rst + newcut, eo - r_pos};
                            n_np    = 2'd3;
                        end else begin
                            n_pc[0] = {rs, rst, rl};
                            n_np    = 2'd1;
                        end
                    end
                    pts_pkg::FN_REMOVE: begin
                        n_pi   = '0;
                        n_need = r_need + {1'b0, p_in} + {1'b0, e_in};
                        if (r_run < r_pos && eo > r_end) begin
                            n_pc[0] = {rs, rst, lft_ln};
                            n_pc[1] = {rs, rmv_st, rmv_ln};
                            n_np    = 2'd2;
                            n_state = pts_pkg::S_WR;
                        end else if (r_run < r_pos) begin
                            n_pc[0] = {rs, rst, lft_ln};
                            n_np    = 2'd1;
                            n_state = pts_pkg::S_WR;
                        end else if (eo > r_end) begin
                            n_pc[0] = {rs, rmv_st, rmv_ln};
                            n_np    = 2'd1;
                            n_state = pts_pkg::S_WR;
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                    pts_pkg::FN_LOCATE: begin
                        if (r_pos >= r_run && r_pos < eo) begin
                            n_strobe = 1'b1;
                            n_pidx   = CW'(r_i);
                            n_poff   = newcut;
                            n_state  = pts_pkg::S_IDLE;
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                    default: begin
                        // fragments
                        if (r_run < r_end && eo > r_pos) begin
                            n_strobe = 1'b1;
                            n_fsrc   = rs;
                            n_fst    = rst + ((r_pos > r_run) ? newcut : '0);
                            n_fln    = span_avail;
                            n_last   = (eo >= r_end);
                        end
                        if (r_run < r_end && eo >= r_end) begin
                            n_state = pts_pkg::S_IDLE;
                        end else begin
                            do_adv = 1'b1;
                        end
                    end
                endcase
            end

            pts_pkg::S_WR: begin
                wr_en = (r_wc < WCW'(MAX_SPANS));
                n_wc  = r_wc + WCW'(1);
                n_pi  = r_pi + 2'd1;
                if ((r_pi + 2'd1) == r_np) begin
                    do_adv = 1'b1;
                end
            end

            pts_pkg::S_FIN: begin
                n_strobe = 1'b1;
                n_state  = pts_pkg::S_IDLE;
                wr_en    = ins_end && (r_wc < WCW'(MAX_SPANS));
                wr_data  = {1'b1, r_app, r_len};
                if (full) begin
                    n_status = pts_pkg::ST_FULL;
                end else begin
                    n_bank  = ~r_bank;
                    n_count = CW'(wcf);
                    if (r_func == pts_pkg::FN_INSERT) begin
                        n_doc  = r_doc + r_len;
                        n_app  = r_app + r_len;
                        n_oapp = r_app;
                        n_odoc = r_doc + r_len;
                    end else begin
                        n_doc  = r_doc - r_len;
                        n_odoc = r_doc - r_len;
                    end
                end
            end

            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase

        // Step to the next span or finish the walk
        if (do_adv) begin
            if (at_last) begin
                if (is_edit) begin
                    n_state = pts_pkg::S_FIN;
                end else begin
                    n_state  = pts_pkg::S_IDLE;
                    n_strobe = 1'b1;
                    n_status = pts_pkg::ST_RANGE;
                    n_last   = 1'b1;
                end
            end else begin
                n_i     = r_i + IW'(1);
                n_state = pts_pkg::S_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pts_pkg::S_IDLE;
            r_bank   <= 1'b0;
            r_count  <= '0;
            r_doc    <= '0;
            r_app    <= '0;
            r_orig   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_count  <= n_count;
            r_doc    <= n_doc;
            r_app    <= n_app;
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                r_orig <= cfg_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_end    <= n_end;
        r_i      <= n_i;
        r_run    <= n_run;
        r_wc     <= n_wc;
        r_need   <= n_need;
        r_pc     <= n_pc;
        r_np     <= n_np;
        r_pi     <= n_pi;
        r_status <= n_status;
        r_pidx   <= n_pidx;
        r_poff   <= n_poff;
        r_fsrc   <= n_fsrc;
        r_fst    <= n_fst;
        r_fln    <= n_fln;
        r_odoc   <= n_odoc;
        r_oapp   <= n_oapp;
        r_last   <= n_last;
    end

    assign busy          = (r_state != pts_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_frag_source = r_fsrc;
    assign o_last        = r_last;

endmodule

@@ hw/rtl/pts_checker.sv @@
// Port-level checks for the piece table span engine, bound to the top level.
// Depends on pts_pkg and piece_table_span_engine.
module pts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_last,
    input logic [1:0]  o_status,
    input logic [39:0] o_frag_length
);

    // A flagged request gives a single, final result
    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != pts_pkg::ST_OK) |-> o_last)
        else $error("flagged result not marked last");

    // Fragments are only reported with ok status
    a_frag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_frag_length != 40'd0) |-> (o_status == pts_pkg::ST_OK))
        else $error("fragment with non-ok status");

    // Leaving the walk always delivers the final result
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_last)
        else $error("walk ended without final result");

    // More fragments pending keeps the block busy
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("idle while fragments pending");

endmodule

bind piece_table_span_engine pts_checker u_pts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_last       (o_last),
    .o_status     (o_status),
    .o_frag_length(o_frag_length)
);
